[sv/gcf_pkg.sv]
package gcf_pkg;

   // Chunk length counter and configuration field widths
   localparam int LENGTH_BITS = 24;
   localparam int AVG_BITS    = 5;
   localparam int MASK_BITS   = 32;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [LENGTH_BITS-1:0] LEN_CAP = {LENGTH_BITS{1'b1}};

   // FNV-1a 64 constants
   localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

   // Gear table generator constants
   localparam logic [63:0] SEED_WORD = 64'h4259544542524149;
   localparam logic [63:0] MIX_STEP  = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_MUL1  = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL2  = 64'h94d049bb133111eb;

   // Configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_LEN  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_AVG_BITS = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_LEN  = 2'd2;

   // Configuration register reset values
   localparam logic [LENGTH_BITS-1:0] MIN_LEN_RESET  = 24'd2048;
   localparam logic [AVG_BITS-1:0]    AVG_BITS_RESET = 5'd13;
   localparam logic [LENGTH_BITS-1:0] MAX_LEN_RESET  = 24'd65536;

   // Queue geometry
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_ADDR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   // Record kinds
   localparam logic KIND_CHUNK = 1'b0;
   localparam logic KIND_FILE  = 1'b1;

   typedef struct packed {
      logic [LENGTH_BITS-1:0] min_len;
      logic [AVG_BITS-1:0]    avg_bits;
      logic [LENGTH_BITS-1:0] max_len;
   } cfg_type;

   // Work handed from the front end to the back end: an optional chunk to
   // fingerprint and an optional whole-file hash, in that order
   typedef struct packed {
      logic                   chunk_valid;
      logic [63:0]            chunk_acc;
      logic [LENGTH_BITS-1:0] chunk_len;
      logic                   file_valid;
      logic [63:0]            file_hash;
   } cmd_type;

   typedef logic [63:0] gear_rom_type [256];

   // Multiply by the FNV prime 2^40 + 0x1b3 as a sum of shifts
   function automatic logic [63:0] fnv_mul(input logic [63:0] x);
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

   // Gear table, filled by splitmix64 at elaboration
   function automatic gear_rom_type build_gear_rom();
      gear_rom_type rom;
      logic [63:0]  s;
      logic [63:0]  z;
      s = SEED_WORD;
      for (int k = 0; k < 256; k++) begin
         s = s + MIX_STEP;
         z = s;
         z = (z ^ (z >> 30)) * MIX_MUL1;
         z = (z ^ (z >> 27)) * MIX_MUL2;
         rom[k] = z ^ (z >> 31);
      end
      return rom;
   endfunction

   localparam gear_rom_type GEAR_ROM = build_gear_rom();

endpackage

[sv/gcf_front.sv]
module gcf_front
   import gcf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // data_byte
   input  logic       req_tuser,   // byte_valid
   input  logic       req_tlast,   // end_of_file
   input  logic       full,
   output logic       push,
   output cmd_type    push_cmd
);

   logic [63:0]            roll_ff, roll_in;
   logic [63:0]            acc_ff, acc_in;
   logic [63:0]            file_ff, file_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;

   logic [63:0]            roll1, acc1, file1;
   logic [LENGTH_BITS-1:0] len1;
   logic [MASK_BITS-1:0]   mask;
   logic                   accept, hit, boundary, tail;

   assign req_tready = !full;
   assign accept     = req_tvalid && !full;

   // State after this transaction's byte, if any
   always_comb begin
      if (req_tuser) begin
         acc1  = fnv_mul(acc_ff ^ 64'(req_tdata));
         file1 = fnv_mul(file_ff ^ 64'(req_tdata));
         roll1 = (roll_ff << 1) + GEAR_ROM[req_tdata];
         len1  = (len_ff != LEN_CAP) ? len_ff + LENGTH_BITS'(1) : len_ff;
      end else begin
         acc1  = acc_ff;
         file1 = file_ff;
         roll1 = roll_ff;
         len1  = len_ff;
      end
   end

   // Rolling mask with avg_bits low ones
   always_comb begin
      for (int i = 0; i < MASK_BITS; i++) begin
         mask[i] = (i < int'(cfg.avg_bits));
      end
   end

   // Boundary and tail classification
   assign hit      = ((roll1[MASK_BITS-1:0] & mask) == '0);
   assign boundary = req_tuser && (len1 >= cfg.min_len) && (hit || (len1 >= cfg.max_len));
   assign tail     = req_tlast && (len1 != '0);

   assign push                 = accept && (boundary || req_tlast);
   assign push_cmd.chunk_valid = boundary || tail;
   assign push_cmd.chunk_acc   = acc1;
   assign push_cmd.chunk_len   = len1;
   assign push_cmd.file_valid  = req_tlast;
   assign push_cmd.file_hash   = file1;

   // Next state
   always_comb begin
      roll_in = roll_ff;
      acc_in  = acc_ff;
      file_in = file_ff;
      len_in  = len_ff;
      if (accept) begin
         if (boundary || req_tlast) begin
            roll_in = '0;
            acc_in  = FNV_BASIS;
            len_in  = '0;
         end else begin
            roll_in = roll1;
            acc_in  = acc1;
            len_in  = len1;
         end
         file_in = req_tlast ? FNV_BASIS : file1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_ff <= '0;
         acc_ff  <= FNV_BASIS;
         file_ff <= FNV_BASIS;
         len_ff  <= '0;
      end else begin
         roll_ff <= roll_in;
         acc_ff  <= acc_in;
         file_ff <= file_in;
         len_ff  <= len_in;
      end
   end

   // End of file leaves the chunk and file state at reset values
   a_eof_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> (len_ff == '0) && (file_ff == FNV_BASIS) && (roll_ff == '0))
      else $error("state not cleared after end of file");

endmodule

[sv/gcf_queue.sv]
module gcf_queue
   import gcf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type                    slot_ff [QUEUE_DEPTH];
   logic [QUEUE_ADDR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_ADDR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]  count_ff, count_in;
   logic                       do_pop;

   assign full       = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_ADDR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_ADDR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_BITS'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - QUEUE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue written while full");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
      else $error("queue occupancy out of range");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) || (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH))
      || (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with occupancy");

endmodule

[sv/gcf_back.sv]
module gcf_back
   import gcf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  cmd_type     head_cmd,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // hash_value, chunk_bytes
   output logic        rsp_tuser,   // record_kind
   output logic        rsp_tlast    // last_of_file
);

   logic                   valid_ff, valid_in;
   logic                   kind_ff;
   logic [63:0]            hash_ff;
   logic [LENGTH_BITS-1:0] len_ff;
   logic                   last_ff;
   logic                   sent_ff, sent_in;

   logic                   load, emit_chunk;
   logic [63:0]            fingerprint;

   // Output slot is free or being emptied this cycle
   assign load       = head_valid && (!valid_ff || rsp_tready);
   assign emit_chunk = head_cmd.chunk_valid && !sent_ff;
   assign pop        = load && (!emit_chunk || !head_cmd.file_valid);

   assign fingerprint = fnv_mul(head_cmd.chunk_acc ^ 64'(head_cmd.chunk_len));

   // Chunk record first, then the file record of the same command
   always_comb begin
      valid_in = valid_ff;
      sent_in  = sent_ff;
      if (load) begin
         valid_in = 1'b1;
         sent_in  = emit_chunk && head_cmd.file_valid;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sent_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sent_ff  <= sent_in;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (load) begin
         if (emit_chunk) begin
            kind_ff <= KIND_CHUNK;
            hash_ff <= fingerprint;
            len_ff  <= head_cmd.chunk_len;
            last_ff <= 1'b0;
         end else begin
            kind_ff <= KIND_FILE;
            hash_ff <= head_cmd.file_hash;
            len_ff  <= '0;
            last_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {len_ff, hash_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

   a_file_record: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == KIND_FILE))
      && (!rsp_tlast || (rsp_tdata[87:64] == '0)))
      else $error("malformed file record");

   a_sent_pending: assert property (@(posedge clock) disable iff (reset)
      sent_ff |-> head_valid && head_cmd.file_valid && head_cmd.chunk_valid)
      else $error("chunk marked sent without a pending file record");

endmodule

[sv/gear_chunker_fnv_fingerprint.sv]
// Content-defined chunker with FNV-1a fingerprints.
// Input channel (req_): one transaction per file byte; req_tuser marks whether
// req_tdata carries a byte, req_tlast ends the file (a bare end mark has
// req_tuser low). Result channel (rsp_): chunk fingerprints (tuser 0) and the
// whole-file hash (tuser 1, tlast 1, length 0), in stream order.
// The user must write the registers through csr_we / csr_index / csr_wdata
// only while idle; the block itself does not enforce this. Throughput: one
// byte per cycle while req_tready is high. The front end updates the gear,
// chunk and file hashes for each accepted transaction and posts work to a
// four-entry queue; the back end emits one record per cycle while records are
// queued and rsp_tready is high, so a transaction that ends a chunk and the file
// gives two records. An accepted transaction is registered in the queue, then in the output register.
// Reset (synchronous) restores default registers, clears hashes and the queue.
// When the receiver stalls, the output holds and the queue fills; req_tready
// falls only when the queue is full.
module gear_chunker_fnv_fingerprint
   import gcf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,   // data_byte
   input  logic                    req_tuser,   // byte_valid
   input  logic                    req_tlast,   // end_of_file
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [87:0]             rsp_tdata,   // hash_value[63:0], chunk_bytes[87:64]
   output logic                    rsp_tuser,   // record_kind
   output logic                    rsp_tlast,   // last_of_file
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [LENGTH_BITS-1:0]  csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    full, push, pop, head_valid;
   cmd_type push_cmd, head_cmd;

   // Configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MIN_LEN:  cfg_in.min_len  = csr_wdata;
            CSR_AVG_BITS: cfg_in.avg_bits = csr_wdata[AVG_BITS-1:0];
            CSR_MAX_LEN:  cfg_in.max_len  = csr_wdata;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_len  <= MIN_LEN_RESET;
         cfg_ff.avg_bits <= AVG_BITS_RESET;
         cfg_ff.max_len  <= MAX_LEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gcf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .full       (full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   gcf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   gcf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[verif/gear_chunker_fnv_fingerprint_test.sv]
`timescale 1ns / 100ps

module gear_chunker_fnv_fingerprint_test;
   import gcf_pkg::*;

   localparam logic [63:0]             FNV_PRIME      = 64'h00000100000001b3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE      = 2'd3;
   localparam int                      HOLD_CYCLES    = 96;
   localparam int                      SETTLE_CYCLES  = 10;
   localparam int                      WATCHDOG_LIMIT = 1000;

   // One output record as the result channel presents it
   typedef struct packed {
      logic                   kind;
      logic [63:0]            hash;
      logic [LENGTH_BITS-1:0] len;
      logic                   last;
   } chunk_record_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [7:0]              req_tdata;
   logic                    req_tuser;
   logic                    req_tlast;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [87:0]             rsp_tdata;   // hash_value[63:0], chunk_bytes[87:64]
   logic                    rsp_tuser;   // record_kind
   logic                    rsp_tlast;   // last_of_file
   logic                    csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [LENGTH_BITS-1:0]  csr_wdata;

   // Predictor state and its copy of the registers
   logic [63:0]            gear_ref [256];
   logic [63:0]            gear_state;
   logic [63:0]            chunk_fnv;
   logic [63:0]            file_fnv;
   logic [LENGTH_BITS-1:0] chunk_count;
   logic [LENGTH_BITS-1:0] min_sel;
   logic [AVG_BITS-1:0]    avg_sel;
   logic [LENGTH_BITS-1:0] max_sel;

   // Newest record at the front, oldest at the back
   chunk_record_type pending_records [$];

   bit idling_on   = 1'b1;
   bit long_hold   = 1'b0;
   int error_count = 0;
   int items_sent  = 0;
   int files_sent  = 0;
   int chunks_seen = 0;
   int totals_seen = 0;
   int settings_used = 0;
   int quiet_cycles = 0;

   gear_chunker_fnv_fingerprint i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Restart the chunk hashes after a boundary or end of file
   task automatic restart_chunk();
      gear_state  = '0;
      chunk_fnv   = FNV_BASIS;
      chunk_count = '0;
   endtask

   task automatic push_chunk();
      pending_records.push_front({KIND_CHUNK,
                                  (chunk_fnv ^ {{(64-LENGTH_BITS){1'b0}}, chunk_count})
                                     * FNV_PRIME,
                                  chunk_count, 1'b0});
   endtask

   // Work out the records that one input transaction produces
   task automatic predict_records(input logic [7:0] data_byte, input logic byte_valid,
                                  input logic end_of_file);
      logic [63:0] roll_mask;
      logic [63:0] wide_byte;
      roll_mask = (64'd1 << avg_sel) - 64'd1;
      wide_byte = {56'd0, data_byte};
      if (byte_valid) begin
         file_fnv   = (file_fnv ^ wide_byte) * FNV_PRIME;
         chunk_fnv  = (chunk_fnv ^ wide_byte) * FNV_PRIME;
         gear_state = (gear_state << 1) + gear_ref[data_byte];
         if (chunk_count != LEN_CAP)
            chunk_count = chunk_count + LENGTH_BITS'(1);
         if (chunk_count >= min_sel &&
             ((gear_state & roll_mask) == 64'd0 || chunk_count >= max_sel)) begin
            push_chunk();
            restart_chunk();
         end
      end
      if (end_of_file) begin
         if (chunk_count != '0)
            push_chunk();
         pending_records.push_front({KIND_FILE, file_fnv, {LENGTH_BITS{1'b0}}, 1'b1});
         restart_chunk();
         file_fnv   = FNV_BASIS;
         files_sent = files_sent + 1;
      end
   endtask

   // Offer one transaction, with an occasional gap in front, and wait for it to go
   task automatic send_item(input logic [7:0] data_byte, input logic byte_valid,
                            input logic end_of_file);
      logic ready_seen;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data_byte;
      req_tuser  <= byte_valid;
      req_tlast  <= end_of_file;
      predict_records(data_byte, byte_valid, end_of_file);
      items_sent = items_sent + 1;
      // Ready is sampled mid-cycle, clear of the edge that takes the transaction
      do begin
         @(negedge clock);
         ready_seen = req_tready;
         @(posedge clock);
      end while (!ready_seen);
   endtask

   // Stop offering and let every outstanding record drain
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_records.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves csr_we high; the caller lowers it after its last write
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [LENGTH_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_MIN_LEN:  min_sel = value;
         CSR_AVG_BITS: avg_sel = value[AVG_BITS-1:0];
         CSR_MAX_LEN:  max_sel = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(input logic [LENGTH_BITS-1:0] min_len,
                             input logic [LENGTH_BITS-1:0] avg_bits,
                             input logic [LENGTH_BITS-1:0] max_len);
      settle();
      write_reg(CSR_MIN_LEN, min_len);
      write_reg(CSR_AVG_BITS, avg_bits);
      write_reg(CSR_MAX_LEN, max_len);
      csr_we <= 1'b0;
      settings_used = settings_used + 1;
   endtask

   // Reset settings: empty file, short files, bare items with and without end mark
   task automatic test_default_settings();
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'h5a, 1'b0, 1'b0);
      send_item(8'ha5, 1'b1, 1'b0);
      send_item(8'hff, 1'b0, 1'b1);
      settle();
   endtask

   // Zero minimum: any byte may close a chunk, even a chunk of one; the spare index is ignored
   task automatic test_zero_minimum();
      write_reg(CSR_SPARE, {LENGTH_BITS{1'b1}});
      csr_we <= 1'b0;
      set_config(24'd0, 24'd13, 24'd65536);
      send_item(8'h01, 1'b1, 1'b0);
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'h7f, 1'b1, 1'b1);
      settle();
   endtask

   // Minimum above maximum, then the widest and narrowest rolling masks, then capped length limits
   task automatic test_mask_extremes();
      int k;
      set_config(24'd6, 24'd31, 24'd2);
      for (k = 0; k < 7; k++)
         send_item(8'(k * 37), 1'b1, k == 6);
      set_config(24'd3, 24'd0, 24'd100);
      for (k = 0; k < 5; k++)
         send_item(8'(255 - k), 1'b1, k == 4);
      set_config({LENGTH_BITS{1'b1}}, 24'd23, {LENGTH_BITS{1'b1}});
      send_item(8'h3c, 1'b1, 1'b0);
      send_item(8'hc3, 1'b1, 1'b1);
      settle();
   endtask

   // Receiver holds off for a long stretch while bytes keep coming
   task automatic test_back_pressure();
      int k;
      set_config(24'd0, 24'd13, 24'd65536);
      long_hold = 1'b1;
      for (k = 0; k < 40; k++)
         send_item(8'($urandom), 1'b1, k == 39);
      settle();
   endtask

   // Whole files with random content under changing settings, some stray items between
   task automatic test_random_files(input int budget);
      int sent;
      int file_len;
      int pick;
      int k;
      bit tail_mark;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 9))
               0: set_config(24'd1, 24'd4, 24'd64);
               1: set_config(24'd0, 24'd2, 24'd16);
               2: set_config(24'd8, 24'd5, 24'd24);
               3: set_config(24'd16, 24'd0, 24'd32);
               4: set_config(24'd1, 24'd31, 24'd12);
               5: set_config(24'd30, 24'd3, 24'd10);
               6: set_config(24'd1, 24'd13, 24'd1);
               7: set_config({LENGTH_BITS{1'b1}}, 24'd31, {LENGTH_BITS{1'b1}});
               8: set_config(MIN_LEN_RESET, 24'(AVG_BITS_RESET), MAX_LEN_RESET);
               default: set_config(24'($urandom_range(0, 40)), 24'($urandom_range(0, 31)),
                                   24'($urandom_range(1, 80)));
            endcase
         end
         pick = $urandom_range(0, 19);
         if (pick == 0)
            file_len = 0;
         else if (pick < 16)
            file_len = $urandom_range(1, 40);
         else
            file_len = $urandom_range(41, 300);
         tail_mark = (file_len == 0) || ($urandom_range(0, 3) == 0);
         for (k = 0; k < file_len; k++) begin
            if ($urandom_range(0, 24) == 0)
               send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, !tail_mark && k == file_len - 1);
            sent = sent + 1;
         end
         if (tail_mark) begin
            send_item(8'($urandom), 1'b0, 1'b1);
            sent = sent + 1;
         end
      end
      settle();
   endtask

   // Receiver: random stalls, or one long hold-off when asked for
   initial begin
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Compare each record leaving the block with the oldest one predicted
   always @(posedge clock) begin
      chunk_record_type seen;
      chunk_record_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = {rsp_tuser, rsp_tdata[63:0], rsp_tdata[87:64], rsp_tlast};
         if (pending_records.size() == 0) begin
            error_count = error_count + 1;
            $display("%0t: unexpected record: kind %0d hash %h len %0d last %0d", $time,
                     seen.kind, seen.hash, seen.len, seen.last);
         end else begin
            want = pending_records.pop_back();
            if (want.kind == KIND_FILE)
               totals_seen = totals_seen + 1;
            else
               chunks_seen = chunks_seen + 1;
            if (seen.kind !== want.kind || seen.hash !== want.hash ||
                seen.len !== want.len || seen.last !== want.last) begin
               error_count = error_count + 1;
               if (error_count <= 40)
                  $display({"%0t: record mismatch: expected kind %0d hash %h len %0d last %0d,",
                            " got kind %0d hash %h len %0d last %0d"}, $time,
                           want.kind, want.hash, want.len, want.last,
                           seen.kind, seen.hash, seen.len, seen.last);
            end
         end
      end
   end

   // Watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d records outstanding", $time,
                  WATCHDOG_LIMIT, pending_records.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      logic [63:0] seed;
      logic [63:0] mix;
      int k;
      // Gear table by splitmix64
      seed = SEED_WORD;
      for (k = 0; k < 256; k++) begin
         seed = seed + 64'h9e3779b97f4a7c15;
         mix  = seed;
         mix  = (mix ^ (mix >> 30)) * 64'hbf58476d1ce4e5b9;
         mix  = (mix ^ (mix >> 27)) * 64'h94d049bb133111eb;
         gear_ref[k] = mix ^ (mix >> 31);
      end
      restart_chunk();
      file_fnv = FNV_BASIS;
      min_sel  = MIN_LEN_RESET;
      avg_sel  = AVG_BITS_RESET;
      max_sel  = MAX_LEN_RESET;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      req_tlast  <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= CSR_MIN_LEN;
      csr_wdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_settings();
      test_zero_minimum();
      test_mask_extremes();
      test_back_pressure();
      test_random_files(1100);
      // Closing stretch at full rate on both sides
      idling_on = 1'b0;
      test_random_files(220);

      settle();
      $display("Sent %0d transactions in %0d files under %0d register settings.",
               items_sent, files_sent, settings_used);
      $display("Checked %0d chunk fingerprints and %0d whole-file hashes.",
               chunks_seen, totals_seen);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

[sim.f]
sv/gcf_pkg.sv
sv/gcf_front.sv
sv/gcf_queue.sv
sv/gcf_back.sv
sv/gear_chunker_fnv_fingerprint.sv
verif/gear_chunker_fnv_fingerprint_test.sv
